[sv/bfr_pkg.sv]
// Package for the bounded queue with replace-all: depth, widths, operation
// codes and the capacity clamp. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfr_pkg;

  // Ring depth and derived widths
  localparam int DEPTH  = 8;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 4;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = 32;
  localparam int OP_W   = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_REPL = 2'd3
  } op_t;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Clamp the programmed capacity into 1..DEPTH
  function automatic cnt_t eff_cap(input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] cx;
    logic [CMP_W-1:0] res;
    cx = CMP_W'(c);
    if (cx == '0) begin
      res = CMP_W'(1);
    end else if (cx > CMP_W'(DEPTH)) begin
      res = CMP_W'(DEPTH);
    end else begin
      res = cx;
    end
    return CNT_W'(res);
  endfunction

  // Step a ring pointer, wrapping at DEPTH
  function automatic ptr_t ring_next(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

[sv/bounded_fifo_with_replace_all.sv]
// Bounded FIFO of signed 32-bit words with enqueue, dequeue, peek and
// replace-all, held in a one-read one-write synchronous RAM. Uses bfr_pkg.
//
// Item timing: start is taken when busy is low. A result strobes out_valid
// for one cycle and must be captured then; the receiver cannot stall it.
// Enqueue, and any operation refused for a full or empty queue, returns its
// result in the cycle after acceptance with busy staying low. Dequeue and
// peek read the head from the registered RAM read port and answer from
// ST_READ. Replace-all walks the occupied entries one at a time, with a
// read step and a compare/write step each. Capacity is clamped to 1..DEPTH;
// lowering it below the count loses no entries.
`timescale 1ns / 1ps
`default_nettype none

module bounded_fifo_with_replace_all
  import bfr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_we,
  input  wire logic [CAP_W-1:0]         cfg_data,
  // item input
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic signed [WORD_W-1:0] in_value,
  input  wire logic signed [WORD_W-1:0] in_target,
  // result output
  output logic                          out_valid,
  output logic                          out_ok,
  output logic signed [WORD_W-1:0]     out_data,
  output logic                          out_is_empty,
  output logic                          out_is_full
);

  // State codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_RA_RD = 2'd2;
  localparam logic [1:0] ST_RA_WR = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  ptr_t              head_r, head_nxt;
  ptr_t              tail_r, tail_nxt;
  cnt_t              cnt_r, cnt_nxt;
  ptr_t              walk_r, walk_nxt;
  cnt_t              left_r, left_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic [WORD_W-1:0] tgt_r, tgt_nxt;

  logic              ov_r, ov_nxt;
  logic              ok_r, ok_nxt;
  logic [WORD_W-1:0] data_r, data_nxt;
  logic              emp_r, emp_nxt;
  logic              full_r, full_nxt;

  // Entry RAM ports
  logic [WORD_W-1:0] mem [DEPTH];
  logic              rd_en;
  ptr_t              rd_addr;
  logic [WORD_W-1:0] rdata_r;
  logic              wr_en;
  ptr_t              wr_addr;
  logic [WORD_W-1:0] wr_data;

  cnt_t cap_eff;
  logic accept;
  op_t  op;

  assign cap_eff = eff_cap(cap_r);
  assign accept  = start && (state_r == ST_IDLE);
  assign op      = op_t'(in_operation);

  // Next-state, RAM control and result logic
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    walk_nxt  = walk_r;
    left_nxt  = left_r;
    val_nxt   = val_r;
    tgt_nxt   = tgt_r;
    ov_nxt    = 1'b0;
    ok_nxt    = ok_r;
    data_nxt  = data_r;
    emp_nxt   = emp_r;
    full_nxt  = full_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    wr_en     = 1'b0;
    wr_addr   = tail_r;
    wr_data   = in_value;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // default: refused, answer at once with the unchanged count
          ov_nxt   = 1'b1;
          ok_nxt   = 1'b0;
          data_nxt = '0;
          emp_nxt  = (cnt_r == '0);
          full_nxt = (cnt_r >= cap_eff);
          unique case (op)
            OP_ENQ: begin
              if (cnt_r < cap_eff) begin
                wr_en    = 1'b1;
                tail_nxt = ring_next(tail_r);
                cnt_nxt  = cnt_r + CNT_W'(1);
                ok_nxt   = 1'b1;
                emp_nxt  = 1'b0;
                full_nxt = (cnt_nxt >= cap_eff);
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (cnt_r != '0) begin
                // read the head; result follows once the data returns
                ov_nxt    = 1'b0;
                rd_en     = 1'b1;
                state_nxt = ST_READ;
                if (op == OP_DEQ) begin
                  head_nxt = ring_next(head_r);
                  cnt_nxt  = cnt_r - CNT_W'(1);
                end
              end
            end
            OP_REPL: begin
              if (cnt_r != '0) begin
                ov_nxt    = 1'b0;
                walk_nxt  = head_r;
                left_nxt  = cnt_r;
                val_nxt   = in_value;
                tgt_nxt   = in_target;
                state_nxt = ST_RA_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // count already reflects a dequeue
        ov_nxt    = 1'b1;
        ok_nxt    = 1'b1;
        data_nxt  = rdata_r;
        emp_nxt   = (cnt_r == '0);
        full_nxt  = (cnt_r >= cap_eff);
        state_nxt = ST_IDLE;
      end
      ST_RA_RD: begin
        rd_en     = 1'b1;
        rd_addr   = walk_r;
        state_nxt = ST_RA_WR;
      end
      ST_RA_WR: begin
        // rewrite a matching entry, then advance the walk
        wr_addr  = walk_r;
        wr_data  = val_r;
        wr_en    = (rdata_r == tgt_r);
        walk_nxt = ring_next(walk_r);
        left_nxt = left_r - CNT_W'(1);
        if (left_r == CNT_W'(1)) begin
          ov_nxt    = 1'b1;
          ok_nxt    = 1'b1;
          data_nxt  = '0;
          emp_nxt   = (cnt_r == '0);
          full_nxt  = (cnt_r >= cap_eff);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RA_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Entry RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    left_r <= left_nxt;
    val_r  <= val_nxt;
    tgt_r  <= tgt_nxt;
    ok_r   <= ok_nxt;
    data_r <= data_nxt;
    emp_r  <= emp_nxt;
    full_r <= full_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = ov_r;
  assign out_ok       = ok_r;
  assign out_data     = data_r;
  assign out_is_empty = emp_r;
  assign out_is_full  = full_r;

endmodule

`default_nettype wire

[sv/bfr_checker.sv]
// Port-level checks for bounded_fifo_with_replace_all, bound to the top
// level below. Uses bfr_pkg for widths and operation codes.
`timescale 1ns / 1ps
`default_nettype none

module bfr_checker
  import bfr_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic [OP_W-1:0]          in_operation,
  input wire logic                     out_valid,
  input wire logic                     out_ok,
  input wire logic signed [WORD_W-1:0] out_data,
  input wire logic                     out_is_empty,
  input wire logic                     out_is_full
);

  // An accepted enqueue answers in the next cycle
  a_enq_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_ENQ) |=> out_valid)
    else $error("enqueue result not in the next cycle");

  // Leaving a multi-cycle operation always delivers its item
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A result only follows an accepted item or ongoing work
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without an item");

  // Failed operations carry zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_data == '0))
    else $error("nonzero data on a failed operation");

  // An empty queue can never be full, since capacity is at least one
  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> !out_is_full)
    else $error("queue reported empty and full");

endmodule

bind bounded_fifo_with_replace_all bfr_checker u_bfr_checker (.*);

`default_nettype wire
